// ----- design/mrd_pkg.sv -----
// ----------------------------------------------------------------------------
// mrd_pkg
// Shared types, codes and the CRC-16/MODBUS nibble table of the request decoder.
// ----------------------------------------------------------------------------
package mrd_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = 4;

  localparam logic [CNT_W-1:0] COUNT_CAP = 4'd9;
  localparam logic [15:0]      CRC_SEED  = 16'hFFFF;

  // frame status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_ADDR = 2'd2;
  localparam logic [1:0] ST_CRC  = 2'd3;

  // command codes
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_READ_ALL  = 4'd1;
  localparam logic [3:0] CMD_READ_MODE = 4'd2;
  localparam logic [3:0] CMD_ON        = 4'd3;
  localparam logic [3:0] CMD_OFF       = 4'd4;
  localparam logic [3:0] CMD_SET_OFS   = 4'd2;

  // function and item codes in the request
  localparam logic [7:0] FN_READ        = 8'h02;
  localparam logic [7:0] FN_WRITE       = 8'h05;
  localparam logic [7:0] ITEM_ALL       = 8'h00;
  localparam logic [7:0] ITEM_MODE      = 8'h01;
  localparam logic [7:0] ITEM_ONOFF     = 8'h02;
  localparam logic [7:0] ITEM_SET_FIRST = 8'h03;
  localparam logic [7:0] ITEM_SET_LAST  = 8'h09;

  localparam logic [15:0] NIB_TAB [16] = '{
    16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
    16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
  };

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  frame_status;
    logic [3:0]  command;
    logic [15:0] set_value;
  } out_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] t;
    t = NIB_TAB[b[3:0] ^ c[3:0]] ^ (c >> 4);
    return NIB_TAB[b[7:4] ^ t[3:0]] ^ (t >> 4);
  endfunction

endpackage

// ----- design/modbus_rtu_request_decoder_top.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_request_decoder_top
// Modbus RTU request checker: length, address and CRC-16 check, command decode.
//
//   channel  ports                          direction  payload
//   in       in_valid / in_stall / in_data  sink       rx_byte, frame_end
//   out      out_valid / out_stall / out_data source   frame_status, command, set_value
//   cfg      cfg_we / cfg_wdata             sink       device_address
//
// one byte accepted per cycle while in_stall is low; a frame's result passes the input
// register and then the result register around the decode
// two table nibble steps of the crc per byte sit in the single decode stage
// rst_n is synchronous; device address resets to 1, count to 0, crc to 0xFFFF
// out_stall holds the result; bytes that end no frame still flow past it
// ----------------------------------------------------------------------------
module modbus_rtu_request_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mrd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mrd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);

  logic [7:0]        device_address_r;
  logic              s1_valid;
  mrd_pkg::in_item_t s1_item;
  logic              s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r <= 8'd1;
    end else if (cfg_we) begin
      device_address_r <= cfg_wdata;
    end
  end

  mrd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .s1_take  (s1_take)
  );

  mrd_frame_core u_frame_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (device_address_r),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .s1_take   (s1_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- design/mrd_in_stage.sv -----
// ----------------------------------------------------------------------------
// mrd_in_stage
// Input register: holds one received byte until the frame core takes it.
// ----------------------------------------------------------------------------
module mrd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mrd_pkg::in_item_t in_data,
  output logic              s1_valid,
  output mrd_pkg::in_item_t s1_item,
  input  logic              s1_take
);

  logic              s1_valid_r;
  mrd_pkg::in_item_t s1_item_r;

  assign in_stall = s1_valid_r && !s1_take;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item_r <= in_data;
    end
  end

endmodule

// ----- design/mrd_frame_core.sv -----
// ----------------------------------------------------------------------------
// mrd_frame_core
// Byte count, frame store and CRC register; classifies the frame at its last
// byte and drives the result register.
// ----------------------------------------------------------------------------
module mrd_frame_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         dev_addr,
  input  logic               s1_valid,
  input  mrd_pkg::in_item_t  s1_item,
  output logic               s1_take,
  output logic               out_valid,
  input  logic               out_stall,
  output mrd_pkg::out_item_t out_data
);

  logic [mrd_pkg::CNT_W-1:0] byte_count_r;
  logic [15:0]               crc_r;
  logic [7:0]                frame_bytes_r [mrd_pkg::FRAME_BYTES];

  logic                      out_valid_r;
  mrd_pkg::out_item_t        out_data_r;

  logic                      adv;
  logic [mrd_pkg::CNT_W-1:0] cnt_inc;
  logic [15:0]               crc_upd;
  logic [7:0]                fb [mrd_pkg::FRAME_BYTES];
  logic [3:0]                cmd;
  mrd_pkg::out_item_t        res;

  assign adv     = !out_valid_r || !out_stall;
  assign s1_take = s1_valid && (!s1_item.frame_end || adv);

  assign cnt_inc = (byte_count_r < mrd_pkg::COUNT_CAP) ? byte_count_r + 4'd1 : byte_count_r;
  assign crc_upd = (byte_count_r < mrd_pkg::CNT_W'(mrd_pkg::FRAME_BYTES - 2))
                   ? mrd_pkg::crc_byte(crc_r, s1_item.rx_byte) : crc_r;

  // frame as it stands with the current byte included
  always_comb begin
    for (int i = 0; i < mrd_pkg::FRAME_BYTES; i++) begin
      fb[i] = (byte_count_r == mrd_pkg::CNT_W'(i)) ? s1_item.rx_byte : frame_bytes_r[i];
    end
  end

  always_comb begin
    cmd = mrd_pkg::CMD_NONE;
    if (fb[2] == 8'h00) begin
      if (fb[1] == mrd_pkg::FN_READ) begin
        if (fb[3] == mrd_pkg::ITEM_ALL) begin
          cmd = mrd_pkg::CMD_READ_ALL;
        end else if (fb[3] == mrd_pkg::ITEM_MODE) begin
          cmd = mrd_pkg::CMD_READ_MODE;
        end
      end else if (fb[1] == mrd_pkg::FN_WRITE) begin
        if (fb[3] == mrd_pkg::ITEM_ONOFF) begin
          if (fb[4] == 8'h00 && fb[5] == 8'h00) begin
            cmd = mrd_pkg::CMD_ON;
          end else if (fb[4] == 8'h00 && fb[5] == 8'h01) begin
            cmd = mrd_pkg::CMD_OFF;
          end
        end else if (fb[3] >= mrd_pkg::ITEM_SET_FIRST && fb[3] <= mrd_pkg::ITEM_SET_LAST) begin
          cmd = fb[3][3:0] + mrd_pkg::CMD_SET_OFS;
        end
      end
    end
  end

  always_comb begin
    res = '0;
    if (cnt_inc != mrd_pkg::CNT_W'(mrd_pkg::FRAME_BYTES)) begin
      res.frame_status = mrd_pkg::ST_LEN;
    end else if (fb[0] != dev_addr) begin
      res.frame_status = mrd_pkg::ST_ADDR;
    end else if (fb[mrd_pkg::FRAME_BYTES-2] != crc_upd[7:0] ||
                 fb[mrd_pkg::FRAME_BYTES-1] != crc_upd[15:8]) begin
      res.frame_status = mrd_pkg::ST_CRC;
    end else begin
      res.frame_status = mrd_pkg::ST_OK;
      res.command      = cmd;
      res.set_value    = {fb[4], fb[5]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      crc_r        <= mrd_pkg::CRC_SEED;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_take) begin
        if (s1_item.frame_end) begin
          byte_count_r <= '0;
          crc_r        <= mrd_pkg::CRC_SEED;
        end else begin
          byte_count_r <= cnt_inc;
          crc_r        <= crc_upd;
        end
      end
      if (adv) begin
        out_valid_r <= s1_valid && s1_item.frame_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && byte_count_r < mrd_pkg::CNT_W'(mrd_pkg::FRAME_BYTES)) begin
      frame_bytes_r[byte_count_r[mrd_pkg::IDX_W-1:0]] <= s1_item.rx_byte;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= mrd_pkg::COUNT_CAP)
    else $error("byte count beyond cap");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && s1_item.frame_end |=> byte_count_r == '0 && crc_r == mrd_pkg::CRC_SEED)
    else $error("count or crc not cleared after frame end");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.frame_status != mrd_pkg::ST_OK |->
      out_data_r.command == mrd_pkg::CMD_NONE && out_data_r.set_value == 16'h0000)
    else $error("rejected frame carries a command or value");

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_valid_r) && out_valid_r |-> $past(s1_take && s1_item.frame_end))
    else $error("result without a frame end transaction");

endmodule

// ----- bench/tb_modbus_rtu_request_decoder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modbus_rtu_request_decoder_top
// Self-checking bench for the Modbus RTU request decoder. A table of directed
// frames covers the length, address and CRC checks and every command. Random
// frames follow under five device addresses, most of them well formed with
// random content, the rest noise, broken CRCs, odd lengths and unterminated
// fragments. A bit-level CRC-16 predictor in the bench works out each verdict that
// the table does not give. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_modbus_rtu_request_decoder_top;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_BYTES  = 320;

  localparam int SEAL_NONE = 0;
  localparam int SEAL_GOOD = 1;
  localparam int SEAL_BAD  = 2;

  localparam logic [3:0] CMD_SET_MAX   = 4'd5;
  localparam logic [3:0] CMD_SET_FIX   = 4'd6;
  localparam logic [3:0] CMD_SET_SYS   = 4'd7;
  localparam logic [3:0] CMD_UNDERVOLT = 4'd8;
  localparam logic [3:0] CMD_OVERVOLT  = 4'd9;
  localparam logic [3:0] CMD_UNDERFREQ = 4'd10;
  localparam logic [3:0] CMD_OVERFREQ  = 4'd11;

  typedef logic [7:0] octets_t [$];

  typedef struct {
    int                 len;
    logic [47:0]        head;
    int                 seal;
    bit                 typed;
    mrd_pkg::out_item_t want;
  } frame_row_t;

  typedef struct {
    bit                 typed;
    mrd_pkg::out_item_t want;
  } row_expect_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  mrd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  mrd_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [7:0]         cfg_wdata;

  // decoder state as the bench sees it
  logic [7:0]  dev_addr_m = 8'h01;
  logic [3:0]  cnt_m = '0;
  logic [15:0] crc_m = mrd_pkg::CRC_SEED;
  logic [7:0]  fb_m [mrd_pkg::FRAME_BYTES] = '{default: 8'h00};

  mrd_pkg::out_item_t verdicts_q [$];
  row_expect_t        typed_q [$];

  bit hold_req = 1'b0;
  bit idle_on  = 1'b1;
  int sent_bytes = 0;
  int n_checked  = 0;
  int n_ok       = 0;
  int mismatches = 0;

  frame_row_t dir_rows [25] = '{
    '{1, 48'h01_00_00_00_00_00, SEAL_NONE, 1'b1, {mrd_pkg::ST_LEN, mrd_pkg::CMD_NONE, 16'h0000}},
    '{7, 48'h01_02_00_00_00_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_LEN, mrd_pkg::CMD_NONE, 16'h0000}},
    '{9, 48'h01_02_00_00_00_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_LEN, mrd_pkg::CMD_NONE, 16'h0000}},
    '{12, 48'hFF_FF_FF_FF_FF_FF, SEAL_GOOD, 1'b1,
      {mrd_pkg::ST_LEN, mrd_pkg::CMD_NONE, 16'h0000}},
    '{8, 48'h02_02_00_00_00_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_ADDR, mrd_pkg::CMD_NONE, 16'h0000}},
    '{8, 48'hFF_FF_FF_FF_FF_FF, SEAL_GOOD, 1'b1, {mrd_pkg::ST_ADDR, mrd_pkg::CMD_NONE, 16'h0000}},
    '{8, 48'h00_00_00_00_00_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_ADDR, mrd_pkg::CMD_NONE, 16'h0000}},
    '{8, 48'h07_02_00_00_00_00, SEAL_BAD, 1'b1, {mrd_pkg::ST_ADDR, mrd_pkg::CMD_NONE, 16'h0000}},
    '{8, 48'h01_02_00_00_00_00, SEAL_BAD, 1'b1, {mrd_pkg::ST_CRC, mrd_pkg::CMD_NONE, 16'h0000}},
    '{8, 48'h01_02_00_00_00_00, SEAL_GOOD, 1'b1,
      {mrd_pkg::ST_OK, mrd_pkg::CMD_READ_ALL, 16'h0000}},
    '{8, 48'h01_02_00_01_AB_CD, SEAL_GOOD, 1'b1,
      {mrd_pkg::ST_OK, mrd_pkg::CMD_READ_MODE, 16'hABCD}},
    '{8, 48'h01_05_00_02_00_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, mrd_pkg::CMD_ON, 16'h0000}},
    '{8, 48'h01_05_00_02_00_01, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, mrd_pkg::CMD_OFF, 16'h0001}},
    '{8, 48'h01_05_00_02_12_34, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, mrd_pkg::CMD_NONE, 16'h1234}},
    '{8, 48'h01_05_00_03_FF_FF, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, CMD_SET_MAX, 16'hFFFF}},
    '{8, 48'h01_05_00_04_00_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, CMD_SET_FIX, 16'h0000}},
    '{8, 48'h01_05_00_05_80_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, CMD_SET_SYS, 16'h8000}},
    '{8, 48'h01_05_00_06_7F_FF, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, CMD_UNDERVOLT, 16'h7FFF}},
    '{8, 48'h01_05_00_07_00_01, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, CMD_OVERVOLT, 16'h0001}},
    '{8, 48'h01_05_00_08_00_FF, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, CMD_UNDERFREQ, 16'h00FF}},
    '{8, 48'h01_05_00_09_FF_00, SEAL_GOOD, 1'b1, {mrd_pkg::ST_OK, CMD_OVERFREQ, 16'hFF00}},
    '{8, 48'h01_05_02_00_00_00, SEAL_GOOD, 1'b0, '0},
    '{8, 48'h01_03_00_00_00_00, SEAL_GOOD, 1'b0, '0},
    '{8, 48'h01_05_00_0A_11_22, SEAL_GOOD, 1'b0, '0},
    '{8, 48'h01_02_00_03_00_00, SEAL_GOOD, 1'b0, '0}
  };

  modbus_rtu_request_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    return r;
  endfunction

  function automatic logic [15:0] crc_of(input octets_t q, input int n);
    logic [15:0] c;
    c = mrd_pkg::CRC_SEED;
    for (int k = 0; k < n && k < q.size(); k++) c = crc16_update(c, q[k]);
    return c;
  endfunction

  // one received byte into the predicted decoder; returns 1 with a verdict at frame end
  function automatic bit absorb_byte(input mrd_pkg::in_item_t it,
                                     output mrd_pkg::out_item_t res);
    res = '0;
    if (cnt_m < mrd_pkg::FRAME_BYTES) fb_m[cnt_m[2:0]] = it.rx_byte;
    if (cnt_m < mrd_pkg::FRAME_BYTES - 2) crc_m = crc16_update(crc_m, it.rx_byte);
    if (cnt_m < mrd_pkg::COUNT_CAP) cnt_m = cnt_m + 4'd1;
    if (!it.frame_end) return 1'b0;
    if (cnt_m != mrd_pkg::FRAME_BYTES) begin
      res.frame_status = mrd_pkg::ST_LEN;
    end else if (fb_m[0] != dev_addr_m) begin
      res.frame_status = mrd_pkg::ST_ADDR;
    end else if ({fb_m[7], fb_m[6]} != crc_m) begin
      res.frame_status = mrd_pkg::ST_CRC;
    end else begin
      res.frame_status = mrd_pkg::ST_OK;
      res.set_value = {fb_m[4], fb_m[5]};
      res.command = mrd_pkg::CMD_NONE;
      if (fb_m[2] == 8'h00) begin
        if (fb_m[1] == mrd_pkg::FN_READ) begin
          if (fb_m[3] == mrd_pkg::ITEM_ALL) res.command = mrd_pkg::CMD_READ_ALL;
          else if (fb_m[3] == mrd_pkg::ITEM_MODE) res.command = mrd_pkg::CMD_READ_MODE;
        end else if (fb_m[1] == mrd_pkg::FN_WRITE) begin
          if (fb_m[3] == mrd_pkg::ITEM_ONOFF) begin
            if ({fb_m[4], fb_m[5]} == 16'h0000) res.command = mrd_pkg::CMD_ON;
            else if ({fb_m[4], fb_m[5]} == 16'h0001) res.command = mrd_pkg::CMD_OFF;
          end else if (fb_m[3] >= mrd_pkg::ITEM_SET_FIRST &&
                       fb_m[3] <= mrd_pkg::ITEM_SET_LAST) begin
            res.command = fb_m[3][3:0] + mrd_pkg::CMD_SET_OFS;
          end
        end
      end
    end
    cnt_m = '0;
    crc_m = mrd_pkg::CRC_SEED;
    return 1'b1;
  endfunction

  function automatic int pause_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(posedge clk) begin
    mrd_pkg::out_item_t want;
    mrd_pkg::out_item_t got;
    row_expect_t        tr;
    if (rst_n && in_valid && !in_stall) begin
      if (absorb_byte(in_data, want)) begin
        if (typed_q.size() > 0) begin
          tr = typed_q.pop_front();
          if (tr.typed) want = tr.want;
        end
        verdicts_q.push_back(want);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      if (verdicts_q.size() == 0) begin
        $display("%0t unexpected result: status %0d cmd %0d value %h", $time,
                 got.frame_status, got.command, got.set_value);
        mismatches++;
      end else begin
        want = verdicts_q.pop_front();
        n_checked++;
        if (want.frame_status == mrd_pkg::ST_OK) n_ok++;
        if (got.frame_status !== want.frame_status || got.command !== want.command ||
            got.set_value !== want.set_value) begin
          $display("%0t mismatch: exp st %0d cmd %0d val %h, got st %0d cmd %0d val %h",
                   $time, want.frame_status, want.command, want.set_value,
                   got.frame_status, got.command, got.set_value);
          mismatches++;
        end
      end
    end
  end

  // result side stalls, plus the long hold-off on request
  initial begin : receiver
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        n = pause_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_byte(input mrd_pkg::in_item_t it);
    int g;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
    g = pause_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_frame(input octets_t fr, input bit ends);
    mrd_pkg::in_item_t it;
    foreach (fr[i]) begin
      it.rx_byte   = fr[i];
      it.frame_end = ends && (i == fr.size() - 1);
      send_byte(it);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_address(input logic [7:0] a);
    cfg_wdata <= a;
    cfg_we    <= 1'b1;
    @(posedge clk);
    dev_addr_m = a;
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame();
    octets_t     fr;
    int          r;
    int          n;
    logic [7:0]  fn;
    logic [7:0]  item;
    logic [15:0] val;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    if (r < 16) begin
      // noise: random bytes; half are unterminated fragments that merge into the next frame
      n = (r < 8) ? $urandom_range(1, 7) : $urandom_range(1, 12);
      repeat (n) fr.push_back(8'($urandom));
      send_frame(fr, r >= 8);
      return;
    end
    r = $urandom_range(0, 9);
    fn = (r < 4) ? mrd_pkg::FN_READ : (r < 9) ? mrd_pkg::FN_WRITE : 8'($urandom);
    if (fn == mrd_pkg::FN_READ)
      item = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                          : 8'($urandom_range(mrd_pkg::ITEM_ALL,
                                                              mrd_pkg::ITEM_MODE));
    else
      item = ($urandom_range(0, 5) == 0) ? 8'($urandom)
                                          : 8'($urandom_range(mrd_pkg::ITEM_ONOFF,
                                                              mrd_pkg::ITEM_SET_LAST));
    val = 16'($urandom);
    if (item == mrd_pkg::ITEM_ONOFF && $urandom_range(0, 2) != 0)
      val = 16'($urandom_range(0, 1));
    fr.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : dev_addr_m);
    fr.push_back(fn);
    fr.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00);
    fr.push_back(item);
    fr.push_back(val[15:8]);
    fr.push_back(val[7:0]);
    c = crc_of(fr, 6);
    fr.push_back(c[7:0]);
    fr.push_back(c[15:8]);
    r = $urandom_range(0, 99);
    if (r < 8) fr[$urandom_range(6, 7)] ^= 8'h01 << $urandom_range(0, 7);
    else if (r < 11) fr.push_back(8'($urandom));
    else if (r < 14) void'(fr.pop_back());
    send_frame(fr, 1'b1);
  endtask

  initial begin : stimulus
    octets_t     fr;
    logic [15:0] c;
    logic [7:0]  addr_plan [5];
    int          quota;
    int          w;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      fr.delete();
      for (int k = 0; k < dir_rows[i].len && k < 6; k++)
        fr.push_back(dir_rows[i].head[47 - 8 * k -: 8]);
      c = crc_of(fr, 6);
      for (int k = 6; k < dir_rows[i].len; k++) begin
        if (k < 8 && dir_rows[i].seal != SEAL_NONE) fr.push_back((k == 6) ? c[7:0] : c[15:8]);
        else fr.push_back(8'hA5 ^ 8'(k));
      end
      if (dir_rows[i].seal == SEAL_BAD) fr[7] ^= 8'h80;
      typed_q.push_back('{dir_rows[i].typed, dir_rows[i].want});
      send_frame(fr, 1'b1);
    end
    settle();

    addr_plan[0] = 8'h00;
    addr_plan[1] = 8'hFF;
    addr_plan[2] = 8'($urandom);
    addr_plan[3] = 8'($urandom);
    addr_plan[4] = 8'h01;
    for (int ph = 0; ph < 5; ph++) begin
      set_address(addr_plan[ph]);
      idle_on = (ph != 3);
      quota = sent_bytes + PHASE_BYTES;
      if (ph == 1) begin
        // receiver holds off while one-byte frames pile up behind it
        hold_req = 1'b1;
        idle_on  = 1'b0;
        repeat (60) send_byte('{8'($urandom), 1'b1});
        idle_on = 1'b1;
        settle();
      end
      while (sent_bytes < quota) begin
        random_frame();
        if (ph == 2 && sent_bytes >= quota - PHASE_BYTES / 2 &&
            sent_bytes < quota - PHASE_BYTES / 2 + 14)
          settle();
      end
      settle();
    end

    in_valid <= 1'b0;
    for (w = 0; w < 20000 && verdicts_q.size() != 0; w++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdicts_q.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, verdicts_q.size());
      mismatches += verdicts_q.size();
    end
    $display("covered %0d bytes and %0d checked frames (%0d accepted) under five addresses,",
             sent_bytes, n_checked, n_ok);
    $display("with 0x00 and 0xFF among them, a long result hold-off and random idling on both sides");
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("%0t timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
